// ===== src/sha1_pkg.sv =====
package sha1_pkg;

  // initial chaining values
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  // round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam int          ROUNDS      = 80;
  localparam logic [6:0]  LAST_ROUND  = 7'(ROUNDS - 1);
  localparam logic [7:0]  PAD_MARK    = 8'h80;
  // block offset where the length field starts (448 bits)
  localparam logic [5:0]  LEN_OFFSET  = 6'd56;
  localparam logic [2:0]  DIGEST_LAST = 3'd4;

  localparam int          QUEUE_DEPTH = 4;
  localparam int          QUEUE_AW    = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       last_byte;
  } q_item_t;

  typedef struct packed {
    logic       shift_en;
    logic [7:0] shift_byte;
    logic       init;
    logic       step;
    logic [6:0] rnd;
    logic       add;
    logic       restart;
    logic [2:0] word_sel;
  } core_ctl_t;

  function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    if (rnd < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      res = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
    logic [31:0] res;
    if (rnd < 7'd20) begin
      res = K0;
    end else if (rnd < 7'd40) begin
      res = K1;
    end else if (rnd < 7'd60) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

// ===== src/sha1_front.sv =====
module sha1_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_has_data,
  input  logic              in_last_byte,
  output logic              q_valid,
  input  logic              q_ready,
  output sha1_pkg::q_item_t q_item
);
  import sha1_pkg::*;

  q_item_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                push, pop;

  assign in_ready = (count_r != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  // drop items that carry no byte and do not end the message
  assign push = in_valid && in_ready && (in_has_data || in_last_byte);
  assign pop  = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data_byte: in_data_byte, has_data: in_has_data,
                           last_byte: in_last_byte};
    end
  end

endmodule

// ===== src/sha1_core.sv =====
module sha1_core (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1_pkg::core_ctl_t ctl,
  output logic [31:0]         digest_word
);
  import sha1_pkg::*;

  // block as 16 words, word 0 in the top bits; bytes and schedule words shift in at the bottom
  logic [511:0] blk_r, blk_nxt;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0]  ch0_r, ch1_r, ch2_r, ch3_r, ch4_r;
  logic [31:0]  w_cur, w_mix, w_new, t_sum;

  assign w_cur = blk_r[511:480];
  // taps: word 13, word 8, word 2, word 0 of the sliding window
  assign w_mix = blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ blk_r[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_sum = {a_r[26:0], a_r[31:27]} + sha1_f(ctl.rnd, b_r, c_r, d_r) + e_r
                 + sha1_k(ctl.rnd) + w_cur;

  always_comb begin
    blk_nxt = blk_r;
    if (ctl.shift_en) begin
      blk_nxt = {blk_r[503:0], ctl.shift_byte};
    end else if (ctl.step) begin
      blk_nxt = {blk_r[479:0], w_new};
    end
  end

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    if (ctl.init) begin
      a_nxt = ch0_r;
      b_nxt = ch1_r;
      c_nxt = ch2_r;
      d_nxt = ch3_r;
      e_nxt = ch4_r;
    end else if (ctl.step) begin
      a_nxt = t_sum;
      b_nxt = a_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      d_nxt = c_r;
      e_nxt = d_r;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.restart) begin
      ch0_r <= H0;
      ch1_r <= H1;
      ch2_r <= H2;
      ch3_r <= H3;
      ch4_r <= H4;
    end else if (ctl.add) begin
      ch0_r <= ch0_r + a_r;
      ch1_r <= ch1_r + b_r;
      ch2_r <= ch2_r + c_r;
      ch3_r <= ch3_r + d_r;
      ch4_r <= ch4_r + e_r;
    end
  end

  always_comb begin
    case (ctl.word_sel)
      3'd0:    digest_word = ch0_r;
      3'd1:    digest_word = ch1_r;
      3'd2:    digest_word = ch2_r;
      3'd3:    digest_word = ch3_r;
      default: digest_word = ch4_r;
    endcase
  end

endmodule

// ===== src/sha1_back.sv =====
module sha1_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  sha1_pkg::q_item_t q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_digest_last
);
  import sha1_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COMP = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_PAD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [1:0] PS_MARK = 2'd0;
  localparam logic [1:0] PS_ZERO = 2'd1;
  localparam logic [1:0] PS_LEN  = 2'd2;
  localparam logic [1:0] PS_DONE = 2'd3;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [63:0] len_r, len_nxt;
  logic [1:0]  pstage_r, pstage_nxt;
  logic [2:0]  len_idx_r, len_idx_nxt;
  logic        pad_on_r, pad_on_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic [7:0]  len_byte;
  core_ctl_t   ctl;

  // length bytes go out most significant first
  assign len_byte = len_r[6'(3'd7 - len_idx_r) * 8 +: 8];

  assign q_ready         = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_word_index  = out_idx_r;
  assign out_digest_last = (out_idx_r == DIGEST_LAST);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    bitlen_nxt  = bitlen_r;
    len_nxt     = len_r;
    pstage_nxt  = pstage_r;
    len_idx_nxt = len_idx_r;
    pad_on_nxt  = pad_on_r;
    rnd_nxt     = rnd_r;
    out_idx_nxt = out_idx_r;
    ctl         = '0;
    ctl.rnd      = rnd_r;
    ctl.word_sel = out_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.last_byte) begin
            pad_on_nxt  = 1'b1;
            pstage_nxt  = PS_MARK;
            len_idx_nxt = '0;
            len_nxt     = q_item.has_data ? bitlen_r + 64'd8 : bitlen_r;
            state_nxt   = ST_PAD;
          end
          if (q_item.has_data) begin
            ctl.shift_en   = 1'b1;
            ctl.shift_byte = q_item.data_byte;
            bitlen_nxt     = bitlen_r + 64'd8;
            fill_nxt       = fill_r + 1'b1;
            if (fill_r == 6'd63) begin
              ctl.init  = 1'b1;
              state_nxt = ST_COMP;
            end
          end
        end
      end

      ST_COMP: begin
        ctl.step = 1'b1;
        rnd_nxt  = rnd_r + 1'b1;
        if (rnd_r == LAST_ROUND) begin
          rnd_nxt   = '0;
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        ctl.add = 1'b1;
        if (!pad_on_r) begin
          state_nxt = ST_IDLE;
        end else if (pstage_r == PS_DONE) begin
          out_idx_nxt = '0;
          state_nxt   = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end

      ST_PAD: begin
        ctl.shift_en = 1'b1;
        fill_nxt     = fill_r + 1'b1;
        case (pstage_r)
          PS_MARK: begin
            ctl.shift_byte = PAD_MARK;
            pstage_nxt     = (fill_nxt == LEN_OFFSET) ? PS_LEN : PS_ZERO;
          end
          PS_ZERO: begin
            ctl.shift_byte = 8'h00;
            if (fill_nxt == LEN_OFFSET) begin
              pstage_nxt = PS_LEN;
            end
          end
          PS_LEN: begin
            ctl.shift_byte = len_byte;
            len_idx_nxt    = len_idx_r + 1'b1;
            if (len_idx_r == 3'd7) begin
              pstage_nxt = PS_DONE;
            end
          end
          default: begin
            ctl.shift_en = 1'b0;
            fill_nxt     = fill_r;
          end
        endcase
        if (ctl.shift_en && fill_r == 6'd63) begin
          ctl.init  = 1'b1;
          state_nxt = ST_COMP;
        end
      end

      ST_OUT: begin
        if (out_ready) begin
          out_idx_nxt = out_idx_r + 1'b1;
          if (out_idx_r == DIGEST_LAST) begin
            // start a fresh message
            ctl.restart = 1'b1;
            bitlen_nxt  = '0;
            fill_nxt    = '0;
            pad_on_nxt  = 1'b0;
            out_idx_nxt = '0;
            state_nxt   = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      bitlen_r  <= '0;
      pstage_r  <= PS_MARK;
      len_idx_r <= '0;
      pad_on_r  <= 1'b0;
      rnd_r     <= '0;
      out_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      bitlen_r  <= bitlen_nxt;
      pstage_r  <= pstage_nxt;
      len_idx_r <= len_idx_nxt;
      pad_on_r  <= pad_on_nxt;
      rnd_r     <= rnd_nxt;
      out_idx_r <= out_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  sha1_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .digest_word (out_digest_word)
  );

endmodule

// ===== src/sha1_hash_engine.sv =====
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    in_data_byte[7:0], in_has_data, in_last_byte
// out_     output     out_valid/out_ready  out_digest_word[31:0], out_word_index[2:0],
//                                          out_digest_last
//
// A four-item queue takes an item per cycle while it has room and drops items with
// neither a byte nor an end flag. The back end packs one byte per cycle and stalls the
// queue while it works; each full block then runs 80 rounds and the chain add.
// Finishing pads one byte per cycle between compressions (9 to 64 bytes, up to 72 over
// two blocks), then shows the five digest words, one per cycle while out_ready is high.
// Synchronous active-low reset clears the queue, counters and chaining words.
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_data,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_digest_last
);
  import sha1_pkg::*;

  logic    q_valid;
  logic    q_ready;
  q_item_t q_item;

  sha1_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_has_data  (in_has_data),
    .in_last_byte (in_last_byte),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item)
  );

  sha1_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_digest_last (out_digest_last)
  );

endmodule

// ===== test/sha1_hash_engine_tb.sv =====
`timescale 1ns / 1ps

module sha1_hash_engine_tb;
  import sha1_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int MESSAGE_ITEMS = 400;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_data = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_digest_last;

  // predictor state
  logic [31:0] sha_chain [5];
  logic [31:0] sha_block [16];
  logic [63:0] msg_bits;
  logic [5:0]  blk_fill;

  q_item_t      pending_q [$];
  digest_word_t digest_q [$];
  q_item_t      bus_item;
  int           pushed_count = 0;
  int           accepted_count = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           burst_left = 1;
  int           gap_left = 0;
  logic [15:0]  ready_pat = 16'hFFFF;
  logic [5:0]   pat_age = 6'd0;

  sha1_hash_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_has_data     (in_has_data),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_digest_last (out_digest_last)
  );

  always #10 clk = ~clk;

  function automatic void restart_message();
    sha_chain[0] = H0;
    sha_chain[1] = H1;
    sha_chain[2] = H2;
    sha_chain[3] = H3;
    sha_chain[4] = H4;
    msg_bits = 64'd0;
    blk_fill = 6'd0;
  endfunction

  function automatic void compress_chain();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) w[r] = sha_block[r];
    for (int r = 16; r < 80; r++) begin
      t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {t[30:0], t[31]};
    end
    a = sha_chain[0];
    b = sha_chain[1];
    c = sha_chain[2];
    d = sha_chain[3];
    e = sha_chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    sha_chain[0] += a;
    sha_chain[1] += b;
    sha_chain[2] += c;
    sha_chain[3] += d;
    sha_chain[4] += e;
  endfunction

  // pack big-endian into the block, compress when it fills
  function automatic void absorb_byte(input logic [7:0] b);
    int sh;
    sh = 8 * (3 - int'(blk_fill[1:0]));
    sha_block[blk_fill[5:2]][sh +: 8] = b;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) compress_chain();
  endfunction

  function automatic void hash_item(input q_item_t it);
    logic [63:0] len;
    if (it.has_data) begin
      absorb_byte(it.data_byte);
      msg_bits = msg_bits + 64'd8;
    end
    if (it.last_byte) begin
      len = msg_bits;
      absorb_byte(PAD_MARK);
      while (blk_fill != LEN_OFFSET) absorb_byte(8'h00);
      for (int i = 7; i >= 0; i--) absorb_byte(len[8*i +: 8]);
      for (int i = 0; i < 5; i++) begin
        digest_q.push_back('{sha_chain[i], 3'(i), (3'(i) == DIGEST_LAST)});
      end
      restart_message();
    end
  endfunction

  task automatic push_item(input logic [7:0] b, input logic has, input logic fin);
    q_item_t it;
    it.data_byte = b;
    it.has_data = has;
    it.last_byte = fin;
    pending_q.push_back(it);
    pushed_count++;
  endtask

  // one message of random bytes, with stray empty items mixed in
  task automatic add_message(input int unsigned len);
    bit split;
    split = (len == 0) || ($urandom_range(0, 2) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b1, !split && (i == len - 1));
    end
    if (split) begin
      push_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  task automatic wait_idle();
    while (accepted_count != pushed_count || digest_q.size() != 0) @(negedge clk);
  endtask

  // sender: bursts of items with random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'h00;
      in_has_data <= 1'b0;
      in_last_byte <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hash_item(bus_item);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0 || pending_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          bus_item = pending_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= bus_item.data_byte;
          in_has_data <= bus_item.has_data;
          in_last_byte <= bus_item.last_byte;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 7) == 0) begin
              burst_left = 150;
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 20);
              gap_left = $urandom_range(0, 12);
            end
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: rotate a stall pattern, reload it now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_pat <= 16'hFFFF;
      pat_age <= 6'd0;
    end else begin
      out_ready <= ready_pat[0];
      pat_age <= pat_age + 6'd1;
      if (pat_age == 6'd63) begin
        case ($urandom_range(0, 3))
          0: ready_pat <= 16'hFFFF;
          1: ready_pat <= 16'($urandom & $urandom) | 16'h0001;
          default: ready_pat <= 16'($urandom) | 16'h0001;
        endcase
      end else begin
        ready_pat <= {ready_pat[0], ready_pat[15:1]};
      end
    end
  end

  always @(posedge clk) begin : digest_check
    digest_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word: got word %h index %0d last %0b", $time,
                 out_digest_word, out_word_index, out_digest_last);
        mismatch_count++;
      end else begin
        want = digest_q.pop_front();
        if (out_digest_word !== want.word) begin
          $display("%0t: digest_word mismatch: expected %h, actual %h", $time,
                   want.word, out_digest_word);
          mismatch_count++;
        end
        if (out_word_index !== want.idx) begin
          $display("%0t: word_index mismatch: expected %0d, actual %0d", $time,
                   want.idx, out_word_index);
          mismatch_count++;
        end
        if (out_digest_last !== want.fin) begin
          $display("%0t: digest_last mismatch: expected %0b, actual %0b", $time,
                   want.fin, out_digest_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    int unsigned edge_lens [9];
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
    restart_message();
    for (int i = 0; i < 16; i++) sha_block[i] = 32'h0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty message, a dropped item, then short known messages with more of both mixed in
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    push_item(8'hA5, 1'b0, 1'b0);
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'h5A, 1'b0, 1'b1);
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'h7F, 1'b1, 1'b0);
    push_item(8'h01, 1'b1, 1'b1);
    push_item(8'hFF, 1'b0, 1'b1);

    // hold the sender until every digest word is back
    wait_idle();

    while (pushed_count < MESSAGE_ITEMS) begin
      if ($urandom_range(0, 3) == 3) len = edge_lens[$urandom_range(0, 8)];
      else len = $urandom_range(0, 15);
      add_message(len);
      while (pending_q.size() > 32) @(negedge clk);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && digest_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
